// ----- rtl/mlfq_pkg.sv -----
// Package with command codes, status codes and process state codes of the scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;
    typedef enum logic [3:0] {
        CMD_ADMIT    = 4'd0,
        CMD_WAKE     = 4'd1,
        CMD_SLEEP    = 4'd2,
        CMD_EXIT     = 4'd3,
        CMD_SYSCALL  = 4'd4,
        CMD_TICK     = 4'd5,
        CMD_DISPATCH = 4'd6,
        CMD_BOOST    = 4'd7,
        CMD_QUERY    = 4'd8
    } t_cmd;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_NONE = 2'd1;
    localparam logic [1:0] STS_FULL = 2'd2;

    localparam logic [1:0] PS_UNUSED   = 2'd0;
    localparam logic [1:0] PS_RUNNABLE = 2'd1;
    localparam logic [1:0] PS_RUNNING  = 2'd2;
    localparam logic [1:0] PS_SLEEPING = 2'd3;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
endpackage

// ----- rtl/mlfq_if.sv -----
// Valid/ready channel interfaces for scheduler requests and results.
`timescale 1ns / 1ps
interface mlfq_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] command;
    logic [5:0] proc_id;
    logic [1:0] level_index;
    modport source (output valid, command, proc_id, level_index, input ready);
    modport sink (input valid, command, proc_id, level_index, output ready);
endinterface

interface mlfq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  chosen_proc;
    logic [1:0]  proc_level;
    logic        must_yield;
    logic [31:0] dispatch_count;
    logic [31:0] syscall_total;
    logic [31:0] level_ticks;
    modport source (output valid, status, chosen_proc, proc_level, must_yield,
                    dispatch_count, syscall_total, level_ticks, input ready);
    modport sink (input valid, status, chosen_proc, proc_level, must_yield,
                  dispatch_count, syscall_total, level_ticks, output ready);
endinterface

// ----- rtl/mlfq_process_scheduler_core.sv -----
// Top level of the multilevel feedback queue scheduler core.
//
//  channel  | dir | signals
//  ---------+-----+---------------------------------------------------
//  i_req    | in  | valid, ready, command, proc_id, level_index
//  o_rsp    | out | valid, ready, status, chosen_proc, proc_level, ...
//  cfg      | in  | i_cfg_we, i_cfg_wdata (base_slice)
//
// A plain request passes through the sequencer states record fetch, tick counter
// fetch, execute and report before its result is presented; a FIFO push adds a state,
// and admit and exit clear the NUM_LEVELS tick counters of the slot one by one.
// Dispatch steps over each empty level and reads and checks each popped entry. Boost
// clears the queues, then reads every slot and pushes each runnable or running one.
// Reset is synchronous and active low; it clears all control state and the process
// state bits. No new request is taken while a request is in progress or its result
// waits.
`timescale 1ns / 1ps
module mlfq_process_scheduler_core #(
    parameter int NUM_PROCS  = 64,
    parameter int NUM_LEVELS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    mlfq_req_if.sink   i_req,
    mlfq_rsp_if.source o_rsp
);
    localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int LW = $clog2(NUM_LEVELS);
    localparam int CW = $clog2(NUM_PROCS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_TRD, S_EXEC, S_PUSH, S_DPOP, S_DRD, S_DCHK,
        S_BCLR, S_BRD, S_BDO, S_FIN, S_OUT
    } t_state;

    t_state r_state;

    // Per-process records: each is a memory read at one address.
    logic [1:0]  r_pstat [NUM_PROCS];   // flip-flops, reset clears
    logic [LW-1:0] m_lvl [NUM_PROCS];
    logic [7:0]  m_slice [NUM_PROCS];
    logic [31:0] m_sys   [NUM_PROCS];
    logic [31:0] m_snap  [NUM_PROCS];
    logic [31:0] m_sched [NUM_PROCS];
    logic [31:0] m_ticks [NUM_PROCS][NUM_LEVELS];
    logic [PW-1:0] m_q   [NUM_LEVELS][NUM_PROCS];

    logic [PW-1:0] r_head [NUM_LEVELS];
    logic [CW-1:0] r_cnt  [NUM_LEVELS];

    logic [7:0]  r_base;
    logic [3:0]  r_cmd;
    logic [1:0]  r_qlvl;
    logic [PW-1:0] r_p;
    logic        r_inrange;
    logic [LW-1:0] r_lv;
    logic [7:0]  r_sl;
    logic [31:0] r_sy, r_sn, r_sc, r_tk;
    logic [1:0]  r_ps;
    logic [LW-1:0] r_push_lvl;
    logic [1:0]  r_status;
    logic        r_yield;
    logic [LW-1:0] r_dl;
    logic [PW-1:0] r_bi;
    logic [5:0]  r_who;
    logic [LW-1:0] r_ti;

    logic [1:0]  r_rsp_status;
    logic [5:0]  r_rsp_chosen;
    logic [1:0]  r_rsp_level;
    logic        r_rsp_yield;
    logic [31:0] r_rsp_disp, r_rsp_sys, r_rsp_ticks;

    // Slice of the current level, capped at 255.
    logic [15:0] w_slice_w;
    logic [7:0]  w_slice;
    logic [8:0]  w_used;
    logic        w_higher;
    always_comb begin
        w_slice_w = 16'(r_base) << r_lv;
        w_slice = (w_slice_w > 16'd255) ? 8'd255 : w_slice_w[7:0];
        w_used = (r_sl < 8'd255) ? 9'(r_sl) + 9'd1 : 9'd255;
        w_higher = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (LW'(i) < r_lv && r_cnt[i] != '0) begin
                w_higher = 1'b1;
            end
        end
    end

    logic [PW:0] w_pos;
    always_comb begin
        w_pos = (PW+1)'(r_head[r_push_lvl]) + (PW+1)'(r_cnt[r_push_lvl]);
        if (w_pos >= (PW+1)'(NUM_PROCS)) begin
            w_pos = w_pos - (PW+1)'(NUM_PROCS);
        end
    end

    logic [PW-1:0] r_qrd;
    logic [PW-1:0] w_hnext;
    assign w_hnext = (r_head[r_dl] == PW'(NUM_PROCS - 1)) ? '0 : r_head[r_dl] + PW'(1);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.status = r_rsp_status;
    assign o_rsp.chosen_proc = r_rsp_chosen;
    assign o_rsp.proc_level = r_rsp_level;
    assign o_rsp.must_yield = r_rsp_yield;
    assign o_rsp.dispatch_count = r_rsp_disp;
    assign o_rsp.syscall_total = r_rsp_sys;
    assign o_rsp.level_ticks = r_rsp_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base <= 8'd2;
            for (int i = 0; i < NUM_PROCS; i++) r_pstat[i] <= mlfq_pkg::PS_UNUSED;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l] <= '0;
                r_cnt[l] <= '0;
            end
        end else begin
            if (i_cfg_we) r_base <= i_cfg_wdata;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_cmd <= i_req.command;
                        r_qlvl <= i_req.level_index;
                        r_p <= PW'(i_req.proc_id);
                        r_inrange <= 32'(i_req.proc_id) < NUM_PROCS;
                        r_who <= i_req.proc_id;
                        r_status <= mlfq_pkg::STS_OK;
                        r_yield <= 1'b0;
                        r_dl <= '0;
                        r_bi <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_ps <= r_inrange ? r_pstat[r_p] : mlfq_pkg::PS_UNUSED;
                    r_lv <= m_lvl[r_p];
                    r_sl <= m_slice[r_p];
                    r_sy <= m_sys[r_p];
                    r_sn <= m_snap[r_p];
                    r_ti <= '0;
                    if (r_cmd == mlfq_pkg::CMD_DISPATCH) r_state <= S_DPOP;
                    else if (r_cmd == mlfq_pkg::CMD_BOOST) r_state <= S_BCLR;
                    else r_state <= S_TRD;
                end
                S_TRD: begin
                    // The tick counter is addressed by the level fetched just before.
                    r_tk <= m_ticks[r_p][r_lv];
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    unique case (r_cmd)
                        mlfq_pkg::CMD_ADMIT: begin
                            if (!r_inrange) begin
                                r_status <= mlfq_pkg::STS_NONE;
                                r_state <= S_FIN;
                            end else if (r_ps == mlfq_pkg::PS_UNUSED) begin
                                r_pstat[r_p] <= mlfq_pkg::PS_RUNNABLE;
                                m_lvl[r_p] <= '0; m_slice[r_p] <= '0;
                                m_sys[r_p] <= '0; m_snap[r_p] <= '0;
                                m_sched[r_p] <= '0;
                                r_ti <= '0;
                                r_push_lvl <= '0;
                                r_state <= S_BDO; // clear tick counters, then push
                            end else r_state <= S_FIN;
                        end
                        mlfq_pkg::CMD_WAKE: begin
                            if (r_ps == mlfq_pkg::PS_UNUSED) begin
                                r_status <= mlfq_pkg::STS_NONE;
                                r_state <= S_FIN;
                            end else if (r_ps == mlfq_pkg::PS_SLEEPING) begin
                                r_pstat[r_p] <= mlfq_pkg::PS_RUNNABLE;
                                r_push_lvl <= r_lv;
                                r_state <= S_PUSH;
                            end else r_state <= S_FIN;
                        end
                        mlfq_pkg::CMD_SLEEP: begin
                            if (r_ps == mlfq_pkg::PS_UNUSED) r_status <= mlfq_pkg::STS_NONE;
                            else r_pstat[r_p] <= mlfq_pkg::PS_SLEEPING;
                            r_state <= S_FIN;
                        end
                        mlfq_pkg::CMD_EXIT: begin
                            if (r_ps == mlfq_pkg::PS_UNUSED) begin
                                r_status <= mlfq_pkg::STS_NONE;
                                r_state <= S_FIN;
                            end else begin
                                r_pstat[r_p] <= mlfq_pkg::PS_UNUSED;
                                m_lvl[r_p] <= '0; m_slice[r_p] <= '0;
                                m_sys[r_p] <= '0; m_snap[r_p] <= '0;
                                m_sched[r_p] <= '0;
                                r_ti <= '0;
                                r_state <= S_BDO;
                            end
                        end
                        mlfq_pkg::CMD_SYSCALL: begin
                            if (r_ps == mlfq_pkg::PS_UNUSED) r_status <= mlfq_pkg::STS_NONE;
                            else if (r_sy != mlfq_pkg::SAT32) m_sys[r_p] <= r_sy + 32'd1;
                            r_state <= S_FIN;
                        end
                        mlfq_pkg::CMD_TICK: begin
                            if (r_ps != mlfq_pkg::PS_RUNNING) begin
                                r_status <= mlfq_pkg::STS_NONE;
                                r_state <= S_FIN;
                            end else begin
                                m_ticks[r_p][r_lv] <=
                                    (r_tk == mlfq_pkg::SAT32) ? r_tk : r_tk + 32'd1;
                                if (w_used >= 9'(w_slice)) begin
                                    // Slice used up: restart it and demote a process
                                    // that made fewer system calls than ticks.
                                    m_slice[r_p] <= '0;
                                    m_snap[r_p] <= r_sy;
                                    r_yield <= 1'b1;
                                    r_pstat[r_p] <= mlfq_pkg::PS_RUNNABLE;
                                    r_state <= S_PUSH;
                                    if ((r_sy - r_sn) < 32'(w_used) &&
                                        32'(r_lv) < NUM_LEVELS - 1) begin
                                        m_lvl[r_p] <= r_lv + LW'(1);
                                        r_push_lvl <= r_lv + LW'(1);
                                    end else r_push_lvl <= r_lv;
                                end else begin
                                    m_slice[r_p] <= w_used[7:0];
                                    r_push_lvl <= r_lv;
                                    if (w_higher) begin
                                        r_yield <= 1'b1;
                                        r_pstat[r_p] <= mlfq_pkg::PS_RUNNABLE;
                                        r_state <= S_PUSH;
                                    end else r_state <= S_FIN;
                                end
                            end
                        end
                        default: begin
                            if (r_ps == mlfq_pkg::PS_UNUSED) r_status <= mlfq_pkg::STS_NONE;
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_PUSH: begin
                    if (r_cnt[r_push_lvl] >= CW'(NUM_PROCS)) begin
                        if (r_cmd != mlfq_pkg::CMD_BOOST) r_status <= mlfq_pkg::STS_FULL;
                    end else begin
                        m_q[r_push_lvl][w_pos[PW-1:0]] <=
                            (r_cmd == mlfq_pkg::CMD_BOOST) ? r_bi : r_p;
                        r_cnt[r_push_lvl] <= r_cnt[r_push_lvl] + CW'(1);
                    end
                    if (r_cmd == mlfq_pkg::CMD_BOOST) begin
                        if (r_bi == PW'(NUM_PROCS - 1)) r_state <= S_FIN;
                        else begin
                            r_bi <= r_bi + PW'(1);
                            r_state <= S_BRD;
                        end
                    end else r_state <= S_FIN;
                end
                S_DPOP: begin
                    // Skip empty levels; read the head of the first non-empty one.
                    if (r_cnt[r_dl] != '0) begin
                        r_qrd <= m_q[r_dl][r_head[r_dl]];
                        r_head[r_dl] <= w_hnext;
                        r_cnt[r_dl] <= r_cnt[r_dl] - CW'(1);
                        r_state <= S_DRD;
                    end else if (32'(r_dl) == NUM_LEVELS - 1) begin
                        r_status <= mlfq_pkg::STS_NONE;
                        r_state <= S_FIN;
                    end else r_dl <= r_dl + LW'(1);
                end
                S_DRD: begin
                    r_ps <= r_pstat[r_qrd];
                    r_sc <= m_sched[r_qrd];
                    r_state <= S_DCHK;
                end
                S_DCHK: begin
                    if (r_ps == mlfq_pkg::PS_RUNNABLE) begin
                        r_pstat[r_qrd] <= mlfq_pkg::PS_RUNNING;
                        m_sched[r_qrd] <= (r_sc == mlfq_pkg::SAT32) ? r_sc : r_sc + 32'd1;
                        r_who <= 6'(r_qrd);
                        r_state <= S_FIN;
                    end else if (32'(r_dl) == NUM_LEVELS - 1) begin
                        r_status <= mlfq_pkg::STS_NONE;
                        r_state <= S_FIN;
                    end else begin
                        r_dl <= r_dl + LW'(1);
                        r_state <= S_DPOP;
                    end
                end
                S_BCLR: begin
                    for (int l = 0; l < NUM_LEVELS; l++) begin
                        r_head[l] <= '0;
                        r_cnt[l] <= '0;
                    end
                    r_push_lvl <= '0;
                    r_state <= S_BRD;
                end
                S_BRD: begin
                    r_sy <= m_sys[r_bi];
                    r_ps <= r_pstat[r_bi];
                    r_state <= S_BDO;
                end
                S_BDO: begin
                    if (r_cmd == mlfq_pkg::CMD_BOOST) begin
                        if (r_ps == mlfq_pkg::PS_RUNNABLE || r_ps == mlfq_pkg::PS_RUNNING) begin
                            m_lvl[r_bi] <= '0;
                            m_slice[r_bi] <= '0;
                            m_snap[r_bi] <= r_sy;
                            r_state <= S_PUSH;
                        end else if (r_bi == PW'(NUM_PROCS - 1)) r_state <= S_FIN;
                        else begin
                            r_bi <= r_bi + PW'(1);
                            r_state <= S_BRD;
                        end
                    end else begin
                        // Clear one tick counter of the slot per cycle.
                        m_ticks[r_p][r_ti] <= '0;
                        if (r_ti == LW'(NUM_LEVELS - 1)) begin
                            r_state <= (r_cmd == mlfq_pkg::CMD_ADMIT) ? S_PUSH : S_FIN;
                        end
                        r_ti <= r_ti + LW'(1);
                    end
                end
                S_FIN: begin
                    // Report the chosen process from its updated record.
                    r_rsp_status <= r_status;
                    r_rsp_chosen <= r_who;
                    r_rsp_yield <= r_yield;
                    if (32'(r_who) < NUM_PROCS &&
                        r_pstat[PW'(r_who)] != mlfq_pkg::PS_UNUSED) begin
                        r_rsp_level <= 2'(m_lvl[PW'(r_who)]);
                        r_rsp_disp <= m_sched[PW'(r_who)];
                        r_rsp_sys <= m_sys[PW'(r_who)];
                        r_rsp_ticks <= (32'(r_qlvl) < NUM_LEVELS) ?
                            m_ticks[PW'(r_who)][LW'(r_qlvl)] : 32'd0;
                    end else begin
                        r_rsp_level <= '0;
                        r_rsp_disp <= '0;
                        r_rsp_sys <= '0;
                        r_rsp_ticks <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_rsp.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- dv/mlfq_process_scheduler_core_tb.sv -----
// Self-checking testbench of the scheduler core: directed table, then random traffic.
`timescale 1ns / 1ps
module mlfq_process_scheduler_core_tb;
    localparam int NPROC = 64;
    localparam int NLVL = 4;
    // Command codes above CMD_QUERY are not defined; the core answers them as a query.
    localparam logic [3:0] CMD_UNDEF_LO = 4'd9;
    localparam logic [3:0] CMD_UNDEF_HI = 4'd15;
    // Boost reads every slot and pushes each runnable or running one before it answers.
    localparam int SETTLE_CYCLES = 2 * NPROC + 32;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  chosen;
        logic [1:0]  level;
        logic        yield_cpu;
        logic [31:0] dispatches;
        logic [31:0] syscalls;
        logic [31:0] ticks;
    } t_sched_rsp;

    typedef struct {
        logic [3:0] cmd;
        logic [5:0] id;
        logic [1:0] lvl;
        bit         none_expected;
    } t_table_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = 8'd0;

    mlfq_req_if req_ch ();
    mlfq_rsp_if rsp_ch ();

    mlfq_process_scheduler_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the scheduler state.
    logic [5:0]  fifo_mem [NLVL][NPROC];
    int          fifo_head [NLVL];
    int          fifo_fill [NLVL];
    logic [1:0]  proc_state [NPROC];
    logic [1:0]  proc_lvl [NPROC];
    int          used_ticks [NPROC];
    logic [31:0] sys_calls [NPROC];
    logic [31:0] sys_mark [NPROC];
    logic [31:0] dispatch_cnt [NPROC];
    logic [31:0] ticks_at_lvl [NPROC][NLVL];
    logic [7:0]  slice_base;

    t_sched_rsp pending_rsp [$];
    bit failed = 1'b0;
    bit no_idle = 1'b0;
    int rsp_stall = 0;
    int idle_cycles = 0;

    function automatic logic [31:0] sat_inc(input logic [31:0] x);
        return (x == mlfq_pkg::SAT32) ? x : x + 32'd1;
    endfunction

    function automatic bit fifo_push(input int lvl, input int id);
        if (fifo_fill[lvl] >= NPROC) return 1'b0;
        fifo_mem[lvl][(fifo_head[lvl] + fifo_fill[lvl]) % NPROC] = id[5:0];
        fifo_fill[lvl]++;
        return 1'b1;
    endfunction

    function automatic int slice_len(input int lvl);
        int s;
        s = int'(slice_base) << lvl;
        return (s > 255) ? 255 : s;
    endfunction

    function automatic void clear_slot(input int id);
        proc_lvl[id] = 2'd0;
        used_ticks[id] = 0;
        sys_calls[id] = 32'd0;
        sys_mark[id] = 32'd0;
        dispatch_cnt[id] = 32'd0;
        for (int l = 0; l < NLVL; l++) ticks_at_lvl[id][l] = 32'd0;
    endfunction

    function automatic void reset_shadow();
        slice_base = 8'd2;
        for (int l = 0; l < NLVL; l++) begin
            fifo_head[l] = 0;
            fifo_fill[l] = 0;
        end
        for (int p = 0; p < NPROC; p++) begin
            proc_state[p] = mlfq_pkg::PS_UNUSED;
            clear_slot(p);
        end
    endfunction

    // Applies one request to the shadow state and returns the response it must produce.
    function automatic t_sched_rsp schedule_step(input logic [3:0] cmd, input logic [5:0] pid,
                                                 input logic [1:0] qlvl);
        t_sched_rsp r;
        int p, who, lvl, used, c;
        bit live, yld;
        logic [31:0] delta;
        p = int'(pid);
        who = p;
        live = (proc_state[p] != mlfq_pkg::PS_UNUSED);
        yld = 1'b0;
        r = '0;
        r.status = mlfq_pkg::STS_OK;
        unique case (cmd)
            mlfq_pkg::CMD_ADMIT: begin
                if (!live) begin
                    clear_slot(p);
                    proc_state[p] = mlfq_pkg::PS_RUNNABLE;
                    if (!fifo_push(0, p)) r.status = mlfq_pkg::STS_FULL;
                end
            end
            mlfq_pkg::CMD_WAKE: begin
                if (!live) r.status = mlfq_pkg::STS_NONE;
                else if (proc_state[p] == mlfq_pkg::PS_SLEEPING) begin
                    proc_state[p] = mlfq_pkg::PS_RUNNABLE;
                    if (!fifo_push(proc_lvl[p], p)) r.status = mlfq_pkg::STS_FULL;
                end
            end
            mlfq_pkg::CMD_SLEEP: begin
                if (!live) r.status = mlfq_pkg::STS_NONE;
                else proc_state[p] = mlfq_pkg::PS_SLEEPING;
            end
            mlfq_pkg::CMD_EXIT: begin
                if (!live) r.status = mlfq_pkg::STS_NONE;
                else begin
                    proc_state[p] = mlfq_pkg::PS_UNUSED;
                    clear_slot(p);
                end
            end
            mlfq_pkg::CMD_SYSCALL: begin
                if (!live) r.status = mlfq_pkg::STS_NONE;
                else sys_calls[p] = sat_inc(sys_calls[p]);
            end
            mlfq_pkg::CMD_TICK: begin
                if (proc_state[p] != mlfq_pkg::PS_RUNNING) r.status = mlfq_pkg::STS_NONE;
                else begin
                    lvl = int'(proc_lvl[p]);
                    used = (used_ticks[p] < 255) ? used_ticks[p] + 1 : 255;
                    used_ticks[p] = used;
                    ticks_at_lvl[p][lvl] = sat_inc(ticks_at_lvl[p][lvl]);
                    delta = sys_calls[p] - sys_mark[p];
                    if (used >= slice_len(lvl)) begin
                        // Slice used up: restart it, demote a process that mostly computed.
                        used_ticks[p] = 0;
                        sys_mark[p] = sys_calls[p];
                        if (delta < 32'(used) && lvl < NLVL - 1) proc_lvl[p] = 2'(lvl + 1);
                        yld = 1'b1;
                    end else begin
                        for (int l = 0; l < lvl; l++)
                            if (fifo_fill[l] != 0) yld = 1'b1;
                    end
                    if (yld) begin
                        proc_state[p] = mlfq_pkg::PS_RUNNABLE;
                        if (!fifo_push(proc_lvl[p], p)) r.status = mlfq_pkg::STS_FULL;
                    end
                end
            end
            mlfq_pkg::CMD_DISPATCH: begin
                r.status = mlfq_pkg::STS_NONE;
                for (int l = 0; l < NLVL; l++) begin
                    if (fifo_fill[l] != 0) begin
                        c = int'(fifo_mem[l][fifo_head[l]]);
                        fifo_head[l] = (fifo_head[l] + 1) % NPROC;
                        fifo_fill[l]--;
                        if (proc_state[c] == mlfq_pkg::PS_RUNNABLE) begin
                            proc_state[c] = mlfq_pkg::PS_RUNNING;
                            dispatch_cnt[c] = sat_inc(dispatch_cnt[c]);
                            who = c;
                            r.status = mlfq_pkg::STS_OK;
                            break;
                        end
                    end
                end
            end
            mlfq_pkg::CMD_BOOST: begin
                for (int l = 0; l < NLVL; l++) begin
                    fifo_head[l] = 0;
                    fifo_fill[l] = 0;
                end
                for (int i = 0; i < NPROC; i++) begin
                    if (proc_state[i] == mlfq_pkg::PS_RUNNABLE ||
                        proc_state[i] == mlfq_pkg::PS_RUNNING) begin
                        proc_lvl[i] = 2'd0;
                        used_ticks[i] = 0;
                        sys_mark[i] = sys_calls[i];
                        void'(fifo_push(0, i));
                    end
                end
            end
            default: begin
                if (!live) r.status = mlfq_pkg::STS_NONE;
            end
        endcase
        r.chosen = who[5:0];
        r.yield_cpu = yld;
        if (proc_state[who] != mlfq_pkg::PS_UNUSED) begin
            r.level = proc_lvl[who];
            r.dispatches = dispatch_cnt[who];
            r.syscalls = sys_calls[who];
            r.ticks = ticks_at_lvl[who][qlvl];
        end
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long stall.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_running();
        int ids [$];
        for (int p = 0; p < NPROC; p++)
            if (proc_state[p] == mlfq_pkg::PS_RUNNING) ids.push_back(p);
        if (ids.size() == 0) return -1;
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    function automatic logic [5:0] pick_id();
        // A small pool of slots keeps processes interacting; the rest spans all slots.
        if ($urandom_range(0, 9) < 7) return 6'($urandom_range(0, 7));
        return 6'($urandom_range(0, NPROC - 1));
    endfunction

    // Issues one request and records what it must answer once the core takes it.
    task automatic send_req(input logic [3:0] cmd, input logic [5:0] pid, input logic [1:0] qlvl,
                            input bit none_expected);
        int gap;
        t_sched_rsp e;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.command <= cmd;
        req_ch.proc_id <= pid;
        req_ch.level_index <= qlvl;
        do @(posedge i_clk); while (!req_ch.ready);
        e = schedule_step(cmd, pid, qlvl);
        if (none_expected) begin
            // Rows on an unused slot or an empty scheduler: the answer is plain to see.
            e = '0;
            e.status = mlfq_pkg::STS_NONE;
            e.chosen = pid;
        end
        pending_rsp.push_back(e);
    endtask

    // Lets the core drain fully, then writes the slice register.
    task automatic set_slice(input logic [7:0] value);
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        slice_base = value;
    endtask

    task automatic random_requests(input int count);
        int r, rid;
        logic [3:0] cmd;
        logic [5:0] pid;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            pid = pick_id();
            if (r < 10) cmd = mlfq_pkg::CMD_ADMIT;
            else if (r < 17) cmd = mlfq_pkg::CMD_WAKE;
            else if (r < 22) cmd = mlfq_pkg::CMD_SLEEP;
            else if (r < 26) cmd = mlfq_pkg::CMD_EXIT;
            else if (r < 36) cmd = mlfq_pkg::CMD_SYSCALL;
            else if (r < 64) cmd = mlfq_pkg::CMD_TICK;
            else if (r < 86) cmd = mlfq_pkg::CMD_DISPATCH;
            else if (r < 89) cmd = mlfq_pkg::CMD_BOOST;
            else if (r < 96) cmd = mlfq_pkg::CMD_QUERY;
            else cmd = 4'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
            // Ticks, system calls and sleeps mostly go to a process that is actually running.
            if ((cmd == mlfq_pkg::CMD_TICK || cmd == mlfq_pkg::CMD_SYSCALL ||
                 cmd == mlfq_pkg::CMD_SLEEP) && $urandom_range(0, 9) < 8) begin
                rid = pick_running();
                if (rid >= 0) pid = 6'(rid);
            end
            send_req(cmd, pid, 2'($urandom_range(0, 3)), 1'b0);
        end
    endtask

    // Directed table. Flagged rows carry their answer; the others go through the predictor.
    t_table_row dir_rows [25] = '{
        '{mlfq_pkg::CMD_QUERY,    6'd5,  2'd0, 1'b1},
        '{mlfq_pkg::CMD_DISPATCH, 6'd63, 2'd3, 1'b1},
        '{mlfq_pkg::CMD_TICK,     6'd7,  2'd0, 1'b1},
        '{mlfq_pkg::CMD_ADMIT,    6'd0,  2'd0, 1'b0},
        '{mlfq_pkg::CMD_ADMIT,    6'd63, 2'd0, 1'b0},
        '{mlfq_pkg::CMD_ADMIT,    6'd0,  2'd0, 1'b0},
        '{mlfq_pkg::CMD_DISPATCH, 6'd42, 2'd0, 1'b0},
        '{mlfq_pkg::CMD_SYSCALL,  6'd0,  2'd0, 1'b0},
        '{mlfq_pkg::CMD_TICK,     6'd0,  2'd0, 1'b0},
        '{mlfq_pkg::CMD_TICK,     6'd0,  2'd1, 1'b0},
        '{mlfq_pkg::CMD_DISPATCH, 6'd0,  2'd0, 1'b0},
        '{mlfq_pkg::CMD_TICK,     6'd63, 2'd0, 1'b0},
        '{mlfq_pkg::CMD_SLEEP,    6'd63, 2'd0, 1'b0},
        '{mlfq_pkg::CMD_WAKE,     6'd63, 2'd0, 1'b0},
        '{mlfq_pkg::CMD_WAKE,     6'd0,  2'd1, 1'b0},
        '{mlfq_pkg::CMD_DISPATCH, 6'd0,  2'd0, 1'b0},
        '{mlfq_pkg::CMD_DISPATCH, 6'd0,  2'd0, 1'b0},
        '{mlfq_pkg::CMD_TICK,     6'd0,  2'd1, 1'b0},
        '{mlfq_pkg::CMD_BOOST,    6'd21, 2'd0, 1'b0},
        '{mlfq_pkg::CMD_QUERY,    6'd0,  2'd1, 1'b0},
        '{mlfq_pkg::CMD_QUERY,    6'd63, 2'd3, 1'b0},
        '{mlfq_pkg::CMD_EXIT,     6'd63, 2'd0, 1'b0},
        '{CMD_UNDEF_HI,           6'd0,  2'd2, 1'b0},
        '{mlfq_pkg::CMD_EXIT,     6'd0,  2'd0, 1'b0},
        '{mlfq_pkg::CMD_SYSCALL,  6'd63, 2'd0, 1'b0}
    };

    initial begin
        int rid;
        req_ch.valid = 1'b0;
        req_ch.command = mlfq_pkg::CMD_QUERY;
        req_ch.proc_id = 6'd0;
        req_ch.level_index = 2'd0;
        reset_shadow();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_req(dir_rows[k].cmd, dir_rows[k].id, dir_rows[k].lvl, dir_rows[k].none_expected);

        set_slice(8'd1);
        random_requests(40);

        // Longest slice: running processes tick against the capped slice of 255.
        set_slice(8'd255);
        no_idle = 1'b1;
        send_req(mlfq_pkg::CMD_BOOST, 6'd0, 2'd0, 1'b0);
        send_req(mlfq_pkg::CMD_ADMIT, 6'd33, 2'd0, 1'b0);
        for (int n = 0; n < 262; n++) begin
            rid = pick_running();
            if (rid < 0) send_req(mlfq_pkg::CMD_DISPATCH, 6'd0, 2'd0, 1'b0);
            else send_req(mlfq_pkg::CMD_TICK, 6'(rid), 2'd0, 1'b0);
        end
        no_idle = 1'b0;

        // Zero slice: every tick runs the slice out.
        set_slice(8'd0);
        random_requests(30);

        // Admit and exit without dispatch pile stale entries into level 0 until it overflows.
        set_slice(8'($urandom_range(1, 254)));
        for (int n = 0; n < 66; n++) begin
            send_req(mlfq_pkg::CMD_ADMIT, 6'd50, 2'd0, 1'b0);
            send_req(mlfq_pkg::CMD_EXIT, 6'd50, 2'd0, 1'b0);
        end
        send_req(mlfq_pkg::CMD_WAKE, 6'd1, 2'd0, 1'b0);
        random_requests(20);

        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (!failed) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Result side: random back-pressure and field-by-field comparison.
    always @(posedge i_clk) begin
        t_sched_rsp e;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_rsp.size() == 0) begin
                    $display("%0t: unexpected result, chosen_proc %0d", $time,
                             rsp_ch.chosen_proc);
                    failed = 1'b1;
                end else begin
                    e = pending_rsp.pop_front();
                    if (rsp_ch.status !== e.status) begin
                        $display("%0t: status exp %0d got %0d", $time, e.status, rsp_ch.status);
                        failed = 1'b1;
                    end
                    if (rsp_ch.chosen_proc !== e.chosen) begin
                        $display("%0t: chosen_proc exp %0d got %0d", $time, e.chosen,
                                 rsp_ch.chosen_proc);
                        failed = 1'b1;
                    end
                    if (rsp_ch.proc_level !== e.level) begin
                        $display("%0t: proc_level exp %0d got %0d", $time, e.level,
                                 rsp_ch.proc_level);
                        failed = 1'b1;
                    end
                    if (rsp_ch.must_yield !== e.yield_cpu) begin
                        $display("%0t: must_yield exp %0d got %0d", $time, e.yield_cpu,
                                 rsp_ch.must_yield);
                        failed = 1'b1;
                    end
                    if (rsp_ch.dispatch_count !== e.dispatches) begin
                        $display("%0t: dispatch_count exp %0d got %0d", $time, e.dispatches,
                                 rsp_ch.dispatch_count);
                        failed = 1'b1;
                    end
                    if (rsp_ch.syscall_total !== e.syscalls) begin
                        $display("%0t: syscall_total exp %0d got %0d", $time, e.syscalls,
                                 rsp_ch.syscall_total);
                        failed = 1'b1;
                    end
                    if (rsp_ch.level_ticks !== e.ticks) begin
                        $display("%0t: level_ticks exp %0d got %0d", $time, e.ticks,
                                 rsp_ch.level_ticks);
                        failed = 1'b1;
                    end
                end
            end
            if (rsp_stall > 0 && !no_idle) begin
                rsp_ch.ready <= 1'b0;
                rsp_stall--;
            end else begin
                rsp_ch.ready <= 1'b1;
                rsp_stall = 0;
                if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap();
            end
        end
    end

    // Watchdog: too long without any request or result moving ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end
endmodule

// ----- filelist.f -----
rtl/mlfq_pkg.sv
rtl/mlfq_if.sv
rtl/mlfq_process_scheduler_core.sv
dv/mlfq_process_scheduler_core_tb.sv
